@@ hdl/rgb_box_blur_3x3_unit_assert.svh @@
// Assertion macros used by the checker module of the box blur unit.
`ifndef RGB_BOX_BLUR_3X3_UNIT_ASSERT_SVH
`define RGB_BOX_BLUR_3X3_UNIT_ASSERT_SVH

// Same-cycle implication, switched off while reset is low.
`define RBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbb assertion failed");

// Next-cycle implication, switched off while reset is low.
`define RBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbb assertion failed");

`endif

@@ hdl/rbb_pkg.sv @@
// Shared constants, types and helpers of the 3x3 box blur unit.
package rbb_pkg;

    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    // Configuration register width and reset values.
    localparam int unsigned CFG_W = 12;
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(1920);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(1080);

    // Register indexes, decoded from paddr[2].
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;
    localparam int unsigned PADDR_W = 3;

    // Position counters hold up to the larger frame dimension itself.
    localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int unsigned CNT_W   = $clog2(MAX_DIM + 1);
    localparam int unsigned AW      = $clog2(MAX_WIDTH);

    localparam int unsigned CH_W  = 8;
    localparam int unsigned PIX_W = 3 * CH_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pixel;

    // One window column: rows r-1, r and r+1 of the same image column.
    typedef struct packed {
        t_pixel top;
        t_pixel mid;
        t_pixel bot;
    } t_col;

    // Index 2 is the newest column, index 0 the oldest.
    typedef t_col [2:0] t_window;

    typedef struct packed {
        logic emit;
        logic border;
        logic last;
    } t_flags;

    typedef struct packed {
        logic          enter;
        logic          wr;
        logic [AW-1:0] addr;
        t_flags        flags;
    } t_item;

    function automatic logic [CNT_W-1:0] clamp_dim(input logic [CFG_W-1:0] raw,
                                                   input int unsigned lim);
        logic [CNT_W-1:0] res;
        if (raw == '0) begin
            res = CNT_W'(1);
        end else if (32'(raw) > lim) begin
            res = CNT_W'(lim);
        end else begin
            res = CNT_W'(raw);
        end
        return res;
    endfunction

endpackage

@@ hdl/rbb_ctrl.sv @@
// Frame position counters, drain sequencing and configuration registers.
module rbb_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_idx,
    input  logic [rbb_pkg::CFG_W-1:0]  i_cfg_data,
    output logic [rbb_pkg::CFG_W-1:0]  o_cfg_width,
    output logic [rbb_pkg::CFG_W-1:0]  o_cfg_height,
    input  logic                       i_accept,
    input  logic                       i_cmd,
    output rbb_pkg::t_item             o_item
);

    localparam int unsigned CW = rbb_pkg::CNT_W;

    logic [rbb_pkg::CFG_W-1:0] r_cfg_width, n_cfg_width;
    logic [rbb_pkg::CFG_W-1:0] r_cfg_height, n_cfg_height;
    logic [CW-1:0] r_w, n_w, r_h, n_h;
    logic [CW-1:0] r_in_col, n_in_col, r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col, r_out_row, n_out_row;
    logic          r_draining, n_draining;

    logic          emit;
    logic          done;

    always_comb begin
        n_cfg_width  = r_cfg_width;
        n_cfg_height = r_cfg_height;
        n_w          = r_w;
        n_h          = r_h;
        n_in_col     = r_in_col;
        n_in_row     = r_in_row;
        n_out_col    = r_out_col;
        n_out_row    = r_out_row;
        n_draining   = r_draining;
        emit         = 1'b0;
        done         = 1'b0;

        o_item.enter        = 1'b0;
        o_item.wr           = 1'b0;
        o_item.addr         = r_in_col[rbb_pkg::AW-1:0];
        o_item.flags.border = (r_out_row == '0) || (r_out_row + CW'(1) >= r_h) ||
                              (r_out_col == '0) || (r_out_col + CW'(1) >= r_w);
        o_item.flags.last   = (r_out_row + CW'(1) >= r_h) && (r_out_col + CW'(1) >= r_w);

        if (i_accept) begin
            if (r_draining) begin
                o_item.enter = 1'b1;
                done         = (r_in_col >= r_w);
                emit         = done || (r_h >= CW'(2)) || (r_in_col != '0);
                n_in_col     = r_in_col + CW'(1);
            end else if (!i_cmd) begin
                o_item.enter = 1'b1;
                o_item.wr    = 1'b1;
                emit         = (r_in_row >= CW'(2)) || ((r_in_row == CW'(1)) && (r_in_col != '0));
                if (r_in_col + CW'(1) >= r_w) begin
                    n_in_col = '0;
                    if (r_in_row + CW'(1) >= r_h) begin
                        n_draining = 1'b1;
                    end else begin
                        n_in_row = r_in_row + CW'(1);
                    end
                end else begin
                    n_in_col = r_in_col + CW'(1);
                end
            end
        end

        if (emit) begin
            if (r_out_col + CW'(1) >= r_w) begin
                n_out_col = '0;
                n_out_row = r_out_row + CW'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end

        // The frame restarts after its marked output or on any register write.
        if (done || i_cfg_we) begin
            n_in_col   = '0;
            n_in_row   = '0;
            n_out_col  = '0;
            n_out_row  = '0;
            n_draining = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_idx)
                rbb_pkg::REG_IDX_WIDTH: begin
                    n_cfg_width = i_cfg_data;
                    n_w         = rbb_pkg::clamp_dim(i_cfg_data, rbb_pkg::MAX_WIDTH);
                end
                rbb_pkg::REG_IDX_HEIGHT: begin
                    n_cfg_height = i_cfg_data;
                    n_h          = rbb_pkg::clamp_dim(i_cfg_data, rbb_pkg::MAX_HEIGHT);
                end
                default: begin
                    n_cfg_width = r_cfg_width;
                end
            endcase
        end

        o_item.flags.emit = emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= rbb_pkg::WIDTH_RST;
            r_cfg_height <= rbb_pkg::HEIGHT_RST;
            r_w          <= rbb_pkg::clamp_dim(rbb_pkg::WIDTH_RST, rbb_pkg::MAX_WIDTH);
            r_h          <= rbb_pkg::clamp_dim(rbb_pkg::HEIGHT_RST, rbb_pkg::MAX_HEIGHT);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_draining   <= 1'b0;
        end else begin
            r_cfg_width  <= n_cfg_width;
            r_cfg_height <= n_cfg_height;
            r_w          <= n_w;
            r_h          <= n_h;
            r_in_col     <= n_in_col;
            r_in_row     <= n_in_row;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            r_draining   <= n_draining;
        end
    end

    assign o_cfg_width  = r_cfg_width;
    assign o_cfg_height = r_cfg_height;

endmodule

@@ hdl/rbb_window.sv @@
// Two-row line memory with read bypass and the 3x3 window shift register.
module rbb_window (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbb_pkg::t_item       i_item,
    input  rbb_pkg::t_pixel      i_pix,
    input  logic                 i_take,
    output logic                 o_s1_free,
    output logic                 o_s2_valid,
    output rbb_pkg::t_flags      o_s2_flags,
    output rbb_pkg::t_window     o_window
);

    localparam int unsigned LW = 2 * rbb_pkg::PIX_W;

    // Each entry holds, for one column, the pixels of the two latest rows:
    // the older one in the upper half.
    logic [LW-1:0] r_mem [rbb_pkg::MAX_WIDTH];
    logic [LW-1:0] r_rd;
    logic          r_fwd;
    logic [LW-1:0] r_fwd_data;

    logic                    r_s1v;
    logic                    r_s1_wr;
    logic [rbb_pkg::AW-1:0]  r_s1_addr;
    rbb_pkg::t_flags         r_s1_flags;
    rbb_pkg::t_pixel         r_s1_pix;

    logic                    r_s2v;
    rbb_pkg::t_flags         r_s2_flags;
    rbb_pkg::t_window        r_win;

    logic [LW-1:0]   line;
    logic            s1_go;
    logic            s2_free;
    logic            wr_en;
    logic [LW-1:0]   wr_data;
    rbb_pkg::t_col   col;

    assign line    = r_fwd ? r_fwd_data : r_rd;
    assign s2_free = !r_s2v || i_take;
    assign s1_go   = r_s1v && s2_free;
    assign wr_en   = s1_go && r_s1_wr;
    assign wr_data = {line[rbb_pkg::PIX_W-1:0], r_s1_pix};

    assign col = '{top: line[LW-1:rbb_pkg::PIX_W], mid: line[rbb_pkg::PIX_W-1:0], bot: r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_s1_addr] <= wr_data;
        end
        if (i_item.enter) begin
            r_rd       <= r_mem[i_item.addr];
            r_fwd      <= wr_en && (r_s1_addr == i_item.addr);
            r_fwd_data <= wr_data;
            r_s1_wr    <= i_item.wr;
            r_s1_addr  <= i_item.addr;
            r_s1_flags <= i_item.flags;
            r_s1_pix   <= i_pix;
        end
        if (s1_go) begin
            r_win      <= {col, r_win[2:1]};
            r_s2_flags <= r_s1_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
        end else begin
            if (i_item.enter) begin
                r_s1v <= 1'b1;
            end else if (s1_go) begin
                r_s1v <= 1'b0;
            end
            if (s1_go) begin
                r_s2v <= 1'b1;
            end else if (i_take) begin
                r_s2v <= 1'b0;
            end
        end
    end

    assign o_s1_free  = !r_s1v || s1_go;
    assign o_s2_valid = r_s2v;
    assign o_s2_flags = r_s2_flags;
    assign o_window   = r_win;

endmodule

@@ hdl/rbb_filter.sv @@
// Neighborhood sums, division by nine, border select and the output register.
module rbb_filter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s2_valid,
    input  rbb_pkg::t_flags      i_flags,
    input  rbb_pkg::t_window     i_window,
    output logic                 o_take,
    input  logic                 i_tready,
    output logic                 o_tvalid,
    output rbb_pkg::t_pixel      o_pix,
    output logic                 o_last
);

    localparam int unsigned SUM_W   = $clog2(9 * ((1 << rbb_pkg::CH_W) - 1) + 1);
    // floor(s / 9) == (s * 1821) >> 14 for every sum of nine 8-bit values.
    localparam int unsigned RECIP    = 1821;
    localparam int unsigned RECIP_SH = 14;
    localparam int unsigned PROD_W   = SUM_W + $clog2(RECIP + 1);

    function automatic logic [rbb_pkg::CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] p;
        p = PROD_W'(s) * PROD_W'(RECIP);
        return p[RECIP_SH +: rbb_pkg::CH_W];
    endfunction

    logic              r_s3v;
    rbb_pkg::t_flags   r_s3_flags;
    logic [SUM_W-1:0]  r_sum_r, r_sum_g, r_sum_b;
    rbb_pkg::t_pixel   r_center;

    logic              r_ov;
    rbb_pkg::t_pixel   r_o_pix;
    logic              r_o_last;

    logic [SUM_W-1:0]  sum_r, sum_g, sum_b;
    logic              out_free;
    logic              s3_go;
    logic              s3_free;
    logic              s2_go;
    logic              load;
    rbb_pkg::t_pixel   n_o_pix;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 3; k++) begin
            sum_r = sum_r + SUM_W'(i_window[k].top.red) + SUM_W'(i_window[k].mid.red)
                          + SUM_W'(i_window[k].bot.red);
            sum_g = sum_g + SUM_W'(i_window[k].top.green) + SUM_W'(i_window[k].mid.green)
                          + SUM_W'(i_window[k].bot.green);
            sum_b = sum_b + SUM_W'(i_window[k].top.blue) + SUM_W'(i_window[k].mid.blue)
                          + SUM_W'(i_window[k].bot.blue);
        end
    end

    assign out_free = !r_ov || i_tready;
    assign s3_go    = r_s3v && (!r_s3_flags.emit || out_free);
    assign s3_free  = !r_s3v || s3_go;
    assign s2_go    = i_s2_valid && s3_free;
    assign load     = s3_go && r_s3_flags.emit;

    always_comb begin
        if (r_s3_flags.border) begin
            n_o_pix = r_center;
        end else begin
            n_o_pix.red   = div9(r_sum_r);
            n_o_pix.green = div9(r_sum_g);
            n_o_pix.blue  = div9(r_sum_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_s3_flags <= i_flags;
            r_sum_r    <= sum_r;
            r_sum_g    <= sum_g;
            r_sum_b    <= sum_b;
            r_center   <= i_window[1].mid;
        end
        if (load) begin
            r_o_pix  <= n_o_pix;
            r_o_last <= r_s3_flags.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3v <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            if (s2_go) begin
                r_s3v <= 1'b1;
            end else if (s3_go) begin
                r_s3v <= 1'b0;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (i_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_take   = s3_free;
    assign o_tvalid = r_ov;
    assign o_pix    = r_o_pix;
    assign o_last   = r_o_last;

endmodule

@@ hdl/rgb_box_blur_3x3_unit.sv @@
// 3x3 box blur of an RGB frame: pixels in raster order in, blurred frame out.
//
// The unit takes the pixels of one frame in raster order and returns the frame
// with every interior pixel replaced by the floor of the mean of its 3x3
// neighborhood, per channel; the first and last row and column pass through
// unchanged, as do frames narrower or shorter than three. An input beat with
// tuser low carries a pixel, one with tuser high is a flush tick. The output of
// raster position n-W-1 (W is the frame width) is produced by input beat n, so
// once the last pixel is in, W+1 further beats (flush ticks, or pixels, whose
// value is then dropped) drain the frame; the final output beat of the frame has
// tlast set and the next beat starts a new frame. A flush tick outside the drain
// is taken and produces nothing. Both registers' values are clamped to 1..2048 when
// used, though they read back as written; writing either one restarts the frame,
// so write them only while the unit is idle. Unless output back-pressure fills the
// internal stages, throughput is one input beat per clock cycle, set by the line
// memory, which does one read and one write per pixel on separate ports (a bypass
// covers a read of the column that is being written). A result reaches the output
// register through four register stages: line memory read, window shift, neighborhood
// sums, then divide and border select. The input side keeps accepting beats while a
// result waits, until the internal stages are full. No memory clearing pass is
// needed after reset.
module rgb_box_blur_3x3_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // tdata: pixel_red [7:0], pixel_green [15:8], pixel_blue [23:16].
    input  logic [23:0]                   i_s_tdata,
    // tuser: cmd [0] (0 pixel, 1 flush tick).
    input  logic                          i_s_tuser,
    // Output stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // tdata: out_red [7:0], out_green [15:8], out_blue [23:16].
    output logic [23:0]                   o_m_tdata,
    output logic                          o_m_tlast,
    // Register port: frame_width at 0x0, frame_height at 0x4.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic                        accept;
    logic                        cfg_we;
    logic [rbb_pkg::CFG_W-1:0]   cfg_width;
    logic [rbb_pkg::CFG_W-1:0]   cfg_height;
    rbb_pkg::t_item              item;
    rbb_pkg::t_pixel             in_pix;
    logic                        s1_free;
    logic                        s2_valid;
    rbb_pkg::t_flags             s2_flags;
    rbb_pkg::t_window            window;
    logic                        take;
    rbb_pkg::t_pixel             out_pix;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    // Register reads decode the same address bit as writes.
    always_comb begin
        case (paddr[2])
            rbb_pkg::REG_IDX_WIDTH:  prdata = 32'(cfg_width);
            rbb_pkg::REG_IDX_HEIGHT: prdata = 32'(cfg_height);
            default:                 prdata = '0;
        endcase
    end

    assign o_s_tready = s1_free;
    assign accept     = i_s_tvalid && o_s_tready;

    assign in_pix.red   = i_s_tdata[7:0];
    assign in_pix.green = i_s_tdata[15:8];
    assign in_pix.blue  = i_s_tdata[23:16];

    rbb_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (paddr[2]),
        .i_cfg_data   (pwdata[rbb_pkg::CFG_W-1:0]),
        .o_cfg_width  (cfg_width),
        .o_cfg_height (cfg_height),
        .i_accept     (accept),
        .i_cmd        (i_s_tuser),
        .o_item       (item)
    );

    rbb_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item),
        .i_pix      (in_pix),
        .i_take     (take),
        .o_s1_free  (s1_free),
        .o_s2_valid (s2_valid),
        .o_s2_flags (s2_flags),
        .o_window   (window)
    );

    rbb_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s2_valid (s2_valid),
        .i_flags    (s2_flags),
        .i_window   (window),
        .o_take     (take),
        .i_tready   (i_m_tready),
        .o_tvalid   (o_m_tvalid),
        .o_pix      (out_pix),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {out_pix.blue, out_pix.green, out_pix.red};

endmodule

@@ hdl/rbb_checker.sv @@
// Port-level checks of the box blur unit and their bind to the top level.
`include "rgb_box_blur_3x3_unit_assert.svh"

module rbb_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic [23:0]                   i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [23:0]                   o_m_tdata,
    input  logic                          o_m_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rbb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready
);

    // A stalled output beat keeps its payload.
    `RBB_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // With the output register free or draining, the input side is never held off.
    `RBB_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready)

    // A register reads back the low twelve bits of what was written to it.
    `RBB_ASSERT_NEXT(a_cfg_readback, i_clk, i_rst_n, psel && penable && pwrite && pready, (paddr[2] != $past(paddr[2])) || ((prdata[11:0] == $past(pwdata[11:0])) && (prdata[31:12] == '0)))

endmodule

bind rgb_box_blur_3x3_unit rbb_checker u_rbb_checker (.*);
